// ===== design/ili_pkg.sv =====
`timescale 1ns / 1ps

package ili_pkg;

    localparam int DEPTH_DEFAULT = 64;

    localparam int KIND_W  = 3;
    localparam int POS_W   = 7;
    localparam int VALUE_W = 32;
    localparam int STAT_W  = 2;

    localparam logic [KIND_W-1:0] K_CLEAR     = 3'd0;
    localparam logic [KIND_W-1:0] K_APPEND    = 3'd1;
    localparam logic [KIND_W-1:0] K_DUMP      = 3'd2;
    localparam logic [KIND_W-1:0] K_INSERT    = 3'd3;
    localparam logic [KIND_W-1:0] K_OVERWRITE = 3'd4;
    localparam logic [KIND_W-1:0] K_DELETE    = 3'd5;

    localparam logic [STAT_W-1:0] ST_OK     = 2'd0;
    localparam logic [STAT_W-1:0] ST_BADPOS = 2'd1;
    localparam logic [STAT_W-1:0] ST_FULL   = 2'd2;
    localparam logic [STAT_W-1:0] ST_EMPTY  = 2'd3;

    // controller -> datapath
    typedef struct packed {
        logic             exec;       // run the accepted item's operation
        logic             dump_emit;  // emit cell 0 and rotate the list
        logic [POS_W-1:0] dump_pos;
        logic             dump_last;
    } ili_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic [POS_W-1:0] count;
        logic             empty;
    } ili_stat_t;

endpackage

// ===== design/ili_datapath.sv =====
`timescale 1ns / 1ps

module ili_datapath #(
    parameter int DEPTH = ili_pkg::DEPTH_DEFAULT
) (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic [ili_pkg::KIND_W-1:0]     kind,
    input  logic [ili_pkg::POS_W-1:0]      position,
    input  logic signed [ili_pkg::VALUE_W-1:0] value,
    input  ili_pkg::ili_cmd_t              cmd,
    output ili_pkg::ili_stat_t             stat,
    output logic [ili_pkg::STAT_W-1:0]     out_status,
    output logic signed [ili_pkg::VALUE_W-1:0] out_value,
    output logic [ili_pkg::POS_W-1:0]      out_position,
    output logic [ili_pkg::POS_W-1:0]      out_count,
    output logic                           out_last
);

    localparam int CW = $clog2(DEPTH + 1);

    logic [CW-1:0] count_reg, count_next;
    logic [ili_pkg::VALUE_W-1:0] cells_reg [DEPTH];
    logic [ili_pkg::VALUE_W-1:0] cells_next [DEPTH];
    logic [ili_pkg::VALUE_W-1:0] shift_up [DEPTH];
    logic [ili_pkg::VALUE_W-1:0] shift_dn [DEPTH];

    logic [ili_pkg::STAT_W-1:0]  status_reg, status_next;
    logic [ili_pkg::VALUE_W-1:0] value_reg, value_next;
    logic [ili_pkg::POS_W-1:0]   position_reg, position_next;
    logic [ili_pkg::POS_W-1:0]   fill_reg, fill_next;
    logic                        last_reg, last_next;

    logic [ili_pkg::POS_W-1:0] count7;
    logic [ili_pkg::POS_W-1:0] idx;
    logic                      full;
    logic                      pos_ok_edit;
    logic                      pos_ok_ins;

    assign count7      = ili_pkg::POS_W'(count_reg);
    assign idx         = position - 7'd1;
    assign full        = (count_reg >= CW'(DEPTH));
    assign pos_ok_edit = (position != '0) && (position <= count7);
    assign pos_ok_ins  = (position != '0) && ({1'b0, position} <= ({1'b0, count7} + 8'd1));

    assign stat.count = count7;
    assign stat.empty = (count_reg == '0);

    // neighbor taps for the parallel shifts
    always_comb begin
        shift_up[0] = cells_reg[0];
        for (int i = 1; i < DEPTH; i++) begin
            shift_up[i] = cells_reg[i-1];
        end
        for (int i = 0; i < DEPTH - 1; i++) begin
            shift_dn[i] = cells_reg[i+1];
        end
        shift_dn[DEPTH-1] = cells_reg[DEPTH-1];
    end

    always_comb begin
        count_next = count_reg;
        cells_next = cells_reg;
        status_next = ili_pkg::ST_OK;
        if (cmd.exec) begin
            unique case (kind)
                ili_pkg::K_CLEAR: begin
                    count_next = '0;
                end
                ili_pkg::K_APPEND: begin
                    if (full) begin
                        status_next = ili_pkg::ST_FULL;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (7'(i) == count7) cells_next[i] = value;
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                ili_pkg::K_DUMP: begin
                    // only reaches here on an empty list
                    status_next = ili_pkg::ST_EMPTY;
                end
                ili_pkg::K_INSERT: begin
                    if (!pos_ok_ins) begin
                        status_next = ili_pkg::ST_BADPOS;
                    end else if (full) begin
                        status_next = ili_pkg::ST_FULL;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (7'(i) > idx) cells_next[i] = shift_up[i];
                            else if (7'(i) == idx) cells_next[i] = value;
                        end
                        count_next = count_reg + CW'(1);
                    end
                end
                ili_pkg::K_OVERWRITE: begin
                    if (!pos_ok_edit) begin
                        status_next = ili_pkg::ST_BADPOS;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (7'(i) == idx) cells_next[i] = value;
                        end
                    end
                end
                ili_pkg::K_DELETE: begin
                    if (!pos_ok_edit) begin
                        status_next = ili_pkg::ST_BADPOS;
                    end else begin
                        for (int i = 0; i < DEPTH; i++) begin
                            if (7'(i) >= idx) cells_next[i] = shift_dn[i];
                        end
                        count_next = count_reg - CW'(1);
                    end
                end
                default: begin
                end
            endcase
        end else if (cmd.dump_emit) begin
            // rotate the occupied cells down by one; head wraps to the tail
            for (int i = 0; i < DEPTH; i++) begin
                if (7'(i) == count7 - 7'd1) cells_next[i] = cells_reg[0];
                else if (7'(i) < count7 - 7'd1) cells_next[i] = shift_dn[i];
            end
        end
    end

    always_comb begin
        value_next    = value_reg;
        position_next = position_reg;
        fill_next     = fill_reg;
        last_next     = last_reg;
        if (cmd.exec) begin
            value_next    = '0;
            position_next = '0;
            fill_next     = ili_pkg::POS_W'(count_next);
            last_next     = 1'b1;
        end else if (cmd.dump_emit) begin
            value_next    = cells_reg[0];
            position_next = cmd.dump_pos;
            fill_next     = count7;
            last_next     = cmd.dump_last;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            count_reg <= '0;
        end else begin
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        cells_reg <= cells_next;
        if (cmd.exec || cmd.dump_emit) begin
            status_reg <= cmd.exec ? status_next : ili_pkg::ST_OK;
        end
        value_reg    <= value_next;
        position_reg <= position_next;
        fill_reg     <= fill_next;
        last_reg     <= last_next;
    end

    assign out_status   = status_reg;
    assign out_value    = value_reg;
    assign out_position = position_reg;
    assign out_count    = fill_reg;
    assign out_last     = last_reg;

endmodule

// ===== design/ili_ctrl.sv =====
`timescale 1ns / 1ps

module ili_ctrl (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    input  logic [ili_pkg::KIND_W-1:0] kind,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    input  ili_pkg::ili_stat_t         stat,
    output ili_pkg::ili_cmd_t          cmd
);

    typedef enum logic [1:0] {
        S_IDLE = 2'b01,
        S_DUMP = 2'b10
    } state_t;

    state_t state_reg, state_next;
    logic [ili_pkg::POS_W-1:0] pos_reg, pos_next;
    logic valid_reg, valid_next;
    logic out_free;
    logic load;

    assign out_free = !valid_reg || m_tready;
    assign s_tready = (state_reg == S_IDLE) && out_free;

    always_comb begin
        state_next = state_reg;
        pos_next   = pos_reg;
        cmd        = '0;
        load       = 1'b0;
        unique case (state_reg)
            S_IDLE: begin
                if (s_tvalid && s_tready) begin
                    load = 1'b1;
                    if (kind == ili_pkg::K_DUMP && !stat.empty) begin
                        cmd.dump_emit = 1'b1;
                        cmd.dump_pos  = 7'd1;
                        cmd.dump_last = (stat.count == 7'd1);
                        if (stat.count != 7'd1) begin
                            state_next = S_DUMP;
                            pos_next   = 7'd2;
                        end
                    end else begin
                        cmd.exec = 1'b1;
                    end
                end
            end
            S_DUMP: begin
                if (out_free) begin
                    load          = 1'b1;
                    cmd.dump_emit = 1'b1;
                    cmd.dump_pos  = pos_reg;
                    cmd.dump_last = (pos_reg == stat.count);
                    pos_next      = pos_reg + 7'd1;
                    if (pos_reg == stat.count) state_next = S_IDLE;
                end
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb begin
        if (load) valid_next = 1'b1;
        else if (m_tready) valid_next = 1'b0;
        else valid_next = valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            valid_reg <= 1'b0;
            pos_reg   <= '0;
        end else begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            pos_reg   <= pos_next;
        end
    end

    assign m_tvalid = valid_reg;

endmodule

// ===== design/indexed_list_insert_delete.sv =====
`timescale 1ns / 1ps
// A result is registered and appears in the cycle after its item's transfer.
// A new item is accepted only while the output register is free or being read; the list cells
// shift in parallel. A dump holds the input off until its last entry has been emitted.
// Reset: synchronous, active low; clears the fill count and output valid. Entry cells
// are not cleared and there is no clearing pass.
module indexed_list_insert_delete #(
    parameter int DEPTH = ili_pkg::DEPTH_DEFAULT
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [39:0] s_tdata,   // [6:0] position, [38:7] value, [39] zero
    input  logic [2:0]  s_tuser,   // [2:0] kind
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [47:0] m_tdata,   // [31:0] entry_value, [38:32] entry_position,
                                   // [45:39] fill_count, [47:46] zero
    output logic [1:0]  m_tuser,   // [1:0] status
    output logic        m_tlast
);

    ili_pkg::ili_cmd_t  cmd;
    ili_pkg::ili_stat_t stat;

    logic signed [ili_pkg::VALUE_W-1:0] out_value;
    logic [ili_pkg::POS_W-1:0]          out_position;
    logic [ili_pkg::POS_W-1:0]          out_count;

    ili_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .kind     (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .stat     (stat),
        .cmd      (cmd)
    );

    ili_datapath #(
        .DEPTH (DEPTH)
    ) u_dp (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .kind         (s_tuser),
        .position     (s_tdata[6:0]),
        .value        (s_tdata[38:7]),
        .cmd          (cmd),
        .stat         (stat),
        .out_status   (m_tuser),
        .out_value    (out_value),
        .out_position (out_position),
        .out_count    (out_count),
        .out_last     (m_tlast)
    );

    assign m_tdata = {2'b00, out_count, out_position, out_value};

endmodule

// ===== design/ili_checker.sv =====
`timescale 1ns / 1ps

module ili_checker #(
    parameter int DEPTH = ili_pkg::DEPTH_DEFAULT
) (
    input logic        aclk,
    input logic        aresetn,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [47:0] m_tdata,
    input logic [1:0]  m_tuser,
    input logic        m_tlast
);

    // a stalled result holds
    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // error results are single, terminal status transfers
    a_status: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tuser != ili_pkg::ST_OK |-> m_tlast && m_tdata[38:32] == 7'd0)
        else $error("bad status result shape");

    // dump entries close exactly on the final position
    a_dump_last: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[38:32] != 7'd0 |-> m_tlast == (m_tdata[38:32] == m_tdata[45:39]))
        else $error("dump last marker mismatch");

    a_count: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> m_tdata[45:39] <= 7'(DEPTH) && m_tdata[38:32] <= m_tdata[45:39])
        else $error("fill count out of range");

    a_reset: assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("output valid after reset");

endmodule

bind indexed_list_insert_delete ili_checker #(.DEPTH(DEPTH)) u_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
);

// ===== sim/tb_indexed_list_insert_delete.sv =====
`timescale 1ns / 1ps

module tb_indexed_list_insert_delete;
    import ili_pkg::*;

    localparam int DEPTH       = DEPTH_DEFAULT;
    localparam int HALF_PERIOD = 6;
    localparam int QUIET_LIMIT = 2000;

    // spare operation codes, the block answers them with a plain ok status
    localparam logic [KIND_W-1:0] K_SPARE_6 = 3'd6;
    localparam logic [KIND_W-1:0] K_SPARE_7 = 3'd7;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [VALUE_W-1:0] value;
        logic [POS_W-1:0]   position;
        logic [POS_W-1:0]   fill;
        logic               last;
    } list_result_t;

    logic        aclk     = 1'b0;
    logic        aresetn  = 1'b0;
    logic        s_tvalid = 1'b0;
    logic        s_tready;
    logic [39:0] s_tdata  = '0;   // [6:0] position, [38:7] value, [39] zero
    logic [2:0]  s_tuser  = '0;   // [2:0] kind
    logic        m_tvalid;
    logic        m_tready = 1'b0;
    logic [47:0] m_tdata;         // [31:0] entry_value, [38:32] entry_position,
                                  // [45:39] fill_count, [47:46] zero
    logic [1:0]  m_tuser;         // [1:0] status
    logic        m_tlast;

    int send_idle_pct  = 0;
    int recv_stall_pct = 0;
    int error_count    = 0;
    int quiet_cycles   = 0;

    // shadow copy of the list contents
    logic [VALUE_W-1:0] list_words [DEPTH];
    int                 list_len = 0;
    list_result_t       due_results [$];

    indexed_list_insert_delete #(.DEPTH(DEPTH)) dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser),
        .m_tlast  (m_tlast)
    );

    always #HALF_PERIOD aclk = ~aclk;

    always @(negedge aclk) begin
        m_tready <= ($urandom_range(99) >= recv_stall_pct);
    end

    function automatic void note_status(input logic [STAT_W-1:0] status);
        list_result_t r;
        r        = '0;
        r.status = status;
        r.fill   = POS_W'(list_len);
        r.last   = 1'b1;
        due_results.push_back(r);
    endfunction

    function automatic void apply_list_op(input logic [KIND_W-1:0]  kind,
                                          input logic [POS_W-1:0]   pos,
                                          input logic [VALUE_W-1:0] val);
        int           p;
        int           i;
        list_result_t r;
        p = int'(pos);
        case (kind)
            K_CLEAR: begin
                list_len = 0;
                note_status(ST_OK);
            end
            K_APPEND: begin
                if (list_len >= DEPTH) begin
                    note_status(ST_FULL);
                end else begin
                    list_words[list_len] = val;
                    list_len++;
                    note_status(ST_OK);
                end
            end
            K_DUMP: begin
                if (list_len == 0) begin
                    note_status(ST_EMPTY);
                end else begin
                    for (i = 0; i < list_len; i++) begin
                        r.status   = ST_OK;
                        r.value    = list_words[i];
                        r.position = POS_W'(i + 1);
                        r.fill     = POS_W'(list_len);
                        r.last     = (i + 1 == list_len);
                        due_results.push_back(r);
                    end
                end
            end
            K_INSERT: begin
                // position count+1 is a legal append; range is checked before fullness
                if (p < 1 || p > list_len + 1) begin
                    note_status(ST_BADPOS);
                end else if (list_len >= DEPTH) begin
                    note_status(ST_FULL);
                end else begin
                    for (i = list_len; i >= p; i--)
                        list_words[i] = list_words[i-1];
                    list_words[p-1] = val;
                    list_len++;
                    note_status(ST_OK);
                end
            end
            K_OVERWRITE: begin
                if (p < 1 || p > list_len) begin
                    note_status(ST_BADPOS);
                end else begin
                    list_words[p-1] = val;
                    note_status(ST_OK);
                end
            end
            K_DELETE: begin
                if (p < 1 || p > list_len) begin
                    note_status(ST_BADPOS);
                end else begin
                    for (i = p - 1; i + 1 < list_len; i++)
                        list_words[i] = list_words[i+1];
                    list_len--;
                    note_status(ST_OK);
                end
            end
            default: note_status(ST_OK);
        endcase
    endfunction

    function automatic void check_field(input string name, input logic [31:0] want,
                                        input logic [31:0] got);
        if (want !== got) begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            error_count++;
        end
    endfunction

    always @(posedge aclk) begin : result_check
        list_result_t want;
        if (aresetn && m_tvalid && m_tready) begin
            if (due_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual status %0d data %0h last %0b",
                         $time, m_tuser, m_tdata, m_tlast);
                error_count++;
            end else begin
                want = due_results.pop_front();
                check_field("status", 32'(want.status), 32'(m_tuser));
                check_field("entry_value", want.value, m_tdata[31:0]);
                check_field("entry_position", 32'(want.position), 32'(m_tdata[38:32]));
                check_field("fill_count", 32'(want.fill), 32'(m_tdata[45:39]));
                check_field("last", 32'(want.last), 32'(m_tlast));
            end
        end
    end

    // a cycle with no transfer on either side counts toward the timeout
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= QUIET_LIMIT) begin
            $display("indexed_list_insert_delete verification failed");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    task automatic send_item(input logic [KIND_W-1:0]  kind,
                             input logic [POS_W-1:0]   pos,
                             input logic [VALUE_W-1:0] val);
        @(negedge aclk);
        while ($urandom_range(99) < send_idle_pct) begin
            s_tvalid <= 1'b0;
            @(negedge aclk);
        end
        s_tvalid <= 1'b1;
        s_tuser  <= kind;
        s_tdata  <= {1'b0, val, pos};
        do @(posedge aclk); while (!s_tready);
        apply_list_op(kind, pos, val);
    endtask

    // hold the input off until every pending result has been seen
    task automatic drain_results;
        @(negedge aclk);
        s_tvalid <= 1'b0;
        while (due_results.size() != 0)
            @(posedge aclk);
    endtask

    function automatic logic [POS_W-1:0] pick_position(input int hi);
        int r;
        r = $urandom_range(9);
        if (r == 0)
            return POS_W'(1);
        else if (r == 1)
            return POS_W'(hi);
        else
            return POS_W'($urandom_range(hi, 1));
    endfunction

    task automatic test_directed;
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_item(K_DUMP, 7'd0, 32'h0);                 // empty dump
        send_item(K_DELETE, 7'd1, 32'h0);
        send_item(K_OVERWRITE, 7'd1, 32'h1);
        send_item(K_INSERT, 7'd0, 32'h2);
        send_item(K_INSERT, 7'd2, 32'h3);
        send_item(K_INSERT, 7'd1, 32'h7FFF_FFFF);
        send_item(K_APPEND, 7'd0, 32'h8000_0000);
        send_item(K_APPEND, 7'd127, 32'hFFFF_FFFF);
        send_item(K_INSERT, 7'd2, 32'h0);               // middle
        send_item(K_INSERT, 7'd5, 32'h0000_0001);       // at count+1
        send_item(K_INSERT, 7'd7, 32'h5555_5555);       // past count+1
        send_item(K_OVERWRITE, 7'd5, 32'hA5A5_A5A5);
        send_item(K_OVERWRITE, 7'd0, 32'h1111_1111);
        send_item(K_OVERWRITE, 7'd127, 32'h2222_2222);
        send_item(K_DELETE, 7'd6, 32'h0);
        send_item(K_DUMP, 7'd0, 32'h0);
        send_item(K_DELETE, 7'd1, 32'h0);
        send_item(K_DELETE, 7'd4, 32'h0);               // last entry
        send_item(K_SPARE_6, 7'd127, 32'hFFFF_FFFF);
        send_item(K_SPARE_7, 7'd64, 32'h8000_0000);
        send_item(K_DUMP, 7'd0, 32'h0);
        send_item(K_CLEAR, 7'd0, 32'h0);
        send_item(K_DUMP, 7'd0, 32'h0);
        drain_results();
    endtask

    task automatic test_full_list;
        int k;
        send_idle_pct  = 0;
        recv_stall_pct = 23;
        send_item(K_CLEAR, 7'd0, 32'h0);
        for (k = 0; k < DEPTH; k++)
            send_item(K_APPEND, POS_W'($urandom_range(127)), $urandom);
        send_item(K_APPEND, 7'd1, 32'h1234_5678);
        send_item(K_INSERT, 7'd1, 32'h1234_5678);
        send_item(K_INSERT, POS_W'(DEPTH + 1), 32'h1234_5678);
        send_item(K_INSERT, POS_W'(DEPTH + 2), 32'h1234_5678);
        send_item(K_OVERWRITE, POS_W'(DEPTH), 32'h8000_0001);
        send_item(K_OVERWRITE, POS_W'(DEPTH + 1), 32'h8000_0001);
        send_item(K_DUMP, 7'd0, 32'h0);
        send_item(K_DELETE, POS_W'(DEPTH), 32'h0);
        send_item(K_DELETE, 7'd1, 32'h0);
        send_item(K_INSERT, POS_W'(DEPTH - 1), 32'h7FFF_FFFF);
        send_item(K_INSERT, 7'd1, 32'h8000_0000);
        send_item(K_DUMP, 7'd0, 32'h0);
        drain_results();
    endtask

    task automatic test_random_mix(input int items, input int idle_pct, input int stall_pct);
        int                  r;
        logic [KIND_W-1:0]   kind;
        logic [POS_W-1:0]    pos;
        send_idle_pct  = idle_pct;
        recv_stall_pct = stall_pct;
        repeat (items) begin
            r   = $urandom_range(99);
            pos = POS_W'($urandom_range(127));
            if (r < 30) begin
                kind = K_APPEND;
            end else if (r < 44) begin
                kind = K_INSERT;
                pos  = pick_position(list_len + 1);
            end else if (r < 54) begin
                kind = K_OVERWRITE;
                if (list_len > 0)
                    pos = pick_position(list_len);
            end else if (r < 68) begin
                kind = K_DELETE;
                if (list_len > 0)
                    pos = pick_position(list_len);
            end else if (r < 74) begin
                kind = K_DUMP;
            end else if (r < 76) begin
                kind = K_CLEAR;
            end else if (r < 80) begin
                kind = $urandom_range(1) ? K_SPARE_6 : K_SPARE_7;
            end else begin
                // positional op with an arbitrary position, mostly rejected
                case ($urandom_range(2))
                    0:       kind = K_INSERT;
                    1:       kind = K_OVERWRITE;
                    default: kind = K_DELETE;
                endcase
            end
            if ($urandom_range(49) == 0)
                drain_results();
            send_item(kind, pos, $urandom);
        end
        drain_results();
    endtask

    initial begin
        repeat (4) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        test_directed();
        test_full_list();
        test_random_mix(85, 0, 0);
        test_random_mix(85, 68, 0);
        test_random_mix(85, 0, 68);
        test_random_mix(85, 23, 23);

        repeat (8) @(posedge aclk);
        if (error_count == 0)
            $display("indexed_list_insert_delete verification clean");
        else
            $display("indexed_list_insert_delete verification failed");
        $finish;
    end

endmodule
